// ===== src/d3q7_pkg.sv =====
// ----------------------------------------------------------------------------
// d3q7_pkg: shared types and constants
// Lattice geometry, operation codes, sequencer states and a size clamp helper.
// ----------------------------------------------------------------------------
package d3q7_pkg;

   localparam int MAX_EDGE  = 16;
   localparam int FRAC_BITS = 16;
   localparam int NUM_DIRS  = 7;
   localparam int EDGE_W    = $clog2(MAX_EDGE + 1);
   localparam int COORD_W   = $clog2(MAX_EDGE);
   localparam int SITE_W    = 3 * COORD_W;
   localparam int MEM_W     = SITE_W + 3;
   localparam int SUM_W     = 34;
   localparam logic [31:0] NEG_ONE = 32'd0 - (32'd1 << FRAC_BITS);

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_STEP = 2'd1,
      OP_READ = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      REG_SIZE_X = 2'd0,
      REG_SIZE_Y = 2'd1,
      REG_SIZE_Z = 2'd2
   } reg_type;

   typedef enum logic [1:0] {
      DIR_X = 2'd0,
      DIR_Y = 2'd1,
      DIR_Z = 2'd2
   } axis_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RD_ISSUE,
      ST_RD_ACC,
      ST_RD_DONE,
      ST_SW_FLAG,
      ST_SW_WAIT,
      ST_SW_NB,
      ST_SW_OWN,
      ST_SW_WRITE,
      ST_SW_WRITE2,
      ST_SW_NEXT,
      ST_OUT
   } state_type;

   // one memory access of the shared distribution port
   typedef struct packed {
      logic              we;
      logic [MEM_W-1:0]  addr;
      logic [31:0]       wdata;
   } mem_req_type;

   // clamp a size register to 1..MAX_EDGE
   function automatic logic [EDGE_W-1:0] clamp_edge(input logic [4:0] r);
      logic [EDGE_W-1:0] res;
      if (r == 5'd0) res = EDGE_W'(1);
      else if (32'(r) > MAX_EDGE) res = EDGE_W'(MAX_EDGE);
      else res = EDGE_W'(r);
      return res;
   endfunction

endpackage

// ===== src/lattice_d3q7_stream_swap_unit.sv =====
// ----------------------------------------------------------------------------
// lattice_d3q7_stream_swap_unit: D3Q7 lattice store with swap streaming
// Loads sites, runs in-place streaming passes and answers site reads.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  req_    | in        | valid / stall    | operation site fluid density direction
//  rsp_    | out       | valid / stall    | kind site_out fluid_out density value status
//  csr_    | in        | valid / ready    | index data
//
// Load writes the seven distribution words and the site flag; read streams
// seven words through the adder; step walks every site, and fluid sites swap
// their links, all through the single distribution memory port.
// Reset only returns the sequencer to idle and sets the size registers to 16;
// the store is undefined until loaded. The request side stalls while an item
// is in work or a result waits on rsp_stall.
module lattice_d3q7_stream_swap_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [11:0] req_site,
   input  logic        req_fluid,
   input  logic [30:0] req_density,
   input  logic [2:0]  req_direction,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [11:0] rsp_site_out,
   output logic        rsp_fluid_out,
   output logic [33:0] rsp_site_density,
   output logic signed [31:0] rsp_value,
   output logic        rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_data
);
   import d3q7_pkg::*;

   logic [4:0]        size_x_ff, size_y_ff, size_z_ff;
   logic              busy;
   mem_req_type       mem_req;
   logic [31:0]       mem_rdata;
   logic              flag_we, flag_wdata, flag_rdata;
   logic [SITE_W-1:0] flag_addr;
   logic [31:0]       value_u;

   assign csr_ready = 1'b1;
   assign req_stall = busy;

   // hold size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= 5'd16;
         size_y_ff <= 5'd16;
         size_z_ff <= 5'd16;
      end else if (csr_valid && csr_ready) begin
         case (reg_type'(csr_index))
            REG_SIZE_X: size_x_ff <= csr_data;
            REG_SIZE_Y: size_y_ff <= csr_data;
            REG_SIZE_Z: size_z_ff <= csr_data;
            default:    size_x_ff <= size_x_ff;
         endcase
      end
   end

   d3q7_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (req_valid && !req_stall),
      .op          (op_type'(req_operation)),
      .site        (req_site),
      .fluid       (req_fluid),
      .density     (req_density),
      .direction   (req_direction),
      .sx          (clamp_edge(size_x_ff)),
      .sy          (clamp_edge(size_y_ff)),
      .sz          (clamp_edge(size_z_ff)),
      .busy        (busy),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_kind    (rsp_kind),
      .out_site    (rsp_site_out),
      .out_fluid   (rsp_fluid_out),
      .out_density (rsp_site_density),
      .out_value   (value_u),
      .out_status  (rsp_status),
      .mem_req     (mem_req),
      .mem_rdata   (mem_rdata),
      .flag_we     (flag_we),
      .flag_addr   (flag_addr),
      .flag_wdata  (flag_wdata),
      .flag_rdata  (flag_rdata)
   );

   assign rsp_value = $signed(value_u);

   d3q7_dist_ram u_ram (
      .clock      (clock),
      .mem_req    (mem_req),
      .mem_rdata  (mem_rdata),
      .flag_we    (flag_we),
      .flag_addr  (flag_addr),
      .flag_wdata (flag_wdata),
      .flag_rdata (flag_rdata)
   );

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken with result pending");
   a_step_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_kind) |-> (rsp_site_density == 34'd0 && rsp_value == 32'sd0))
      else $error("step result carries data");
   a_bad_site: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_kind && !rsp_fluid_out))
      else $error("outside read malformed");
`endif

endmodule

// ===== src/d3q7_dist_ram.sv =====
// ----------------------------------------------------------------------------
// d3q7_dist_ram: distribution and flag store
// One port memory of seven words per site plus a per-site flag memory.
// ----------------------------------------------------------------------------
module d3q7_dist_ram (
   input  logic                        clock,
   input  d3q7_pkg::mem_req_type       mem_req,
   output logic [31:0]                 mem_rdata,
   input  logic                        flag_we,
   input  logic [d3q7_pkg::SITE_W-1:0] flag_addr,
   input  logic                        flag_wdata,
   output logic                        flag_rdata
);
   import d3q7_pkg::*;

   logic [31:0] dist_mem [0:(1 << MEM_W) - 1];
   logic        flag_mem [0:(1 << SITE_W) - 1];

   // write or read one distribution word
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         dist_mem[mem_req.addr] <= mem_req.wdata;
      end
      mem_rdata <= dist_mem[mem_req.addr];
   end

   // write or read one site flag
   always_ff @(posedge clock) begin
      if (flag_we) begin
         flag_mem[flag_addr] <= flag_wdata;
      end
      flag_rdata <= flag_mem[flag_addr];
   end

endmodule

// ===== src/d3q7_seq.sv =====
// ----------------------------------------------------------------------------
// d3q7_seq: operation sequencer
// Walks loads, reads and streaming passes over the single memory port,
// with one adder for the read sums.
// ----------------------------------------------------------------------------
module d3q7_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  d3q7_pkg::op_type            op,
   input  logic [11:0]                 site,
   input  logic                        fluid,
   input  logic [30:0]                 density,
   input  logic [2:0]                  direction,
   input  logic [d3q7_pkg::EDGE_W-1:0] sx,
   input  logic [d3q7_pkg::EDGE_W-1:0] sy,
   input  logic [d3q7_pkg::EDGE_W-1:0] sz,
   output logic                        busy,
   output logic                        out_valid,
   input  logic                        out_stall,
   output logic                        out_kind,
   output logic [11:0]                 out_site,
   output logic                        out_fluid,
   output logic [33:0]                 out_density,
   output logic [31:0]                 out_value,
   output logic                        out_status,
   output d3q7_pkg::mem_req_type       mem_req,
   input  logic [31:0]                 mem_rdata,
   output logic                        flag_we,
   output logic [d3q7_pkg::SITE_W-1:0] flag_addr,
   output logic                        flag_wdata,
   input  logic                        flag_rdata
);
   import d3q7_pkg::*;

   state_type          state_ff, state_in;
   logic [SITE_W-1:0]  site_ff, site_in;
   logic [COORD_W-1:0] ci_ff, ci_in, cj_ff, cj_in, ck_ff, ck_in;
   logic [2:0]         dir_ff, dir_in;
   logic [2:0]         sel_ff, sel_in;
   logic               fluid_ff, fluid_in;
   logic [30:0]        dens_ff, dens_in;
   logic [SUM_W:0]     acc_ff, acc_in;
   logic [31:0]        pick_ff, pick_in;
   logic [31:0]        nb_ff, nb_in;
   axis_type           axis_ff, axis_in;
   logic [SITE_W-1:0]  nsite_ff, nsite_in;
   logic               kind_ff, kind_in, status_ff, status_in;
   logic [11:0]        osite_ff, osite_in;
   logic [31:0]        third, ninth;
   logic [SITE_W-1:0]  nb_site;
   logic [SITE_W-1:0]  site_t;
   logic               last_site;
   logic [SUM_W:0]     acc_sum;

   // divide by 3 and 9 through reciprocal products
   assign third = 32'((64'(density) * 64'h5555_5556) >> 32);
   assign ninth = 32'((64'(density) * 64'h38E3_8E39) >> 33);

   assign site_t  = SITE_W'(site);
   assign busy    = (state_ff != ST_IDLE);
   assign out_valid = (state_ff == ST_OUT);
   assign last_site = (32'(ci_ff) + 1 >= 32'(sx)) && (32'(cj_ff) + 1 >= 32'(sy))
                      && (32'(ck_ff) + 1 >= 32'(sz));

   // periodic neighbor site along the current axis
   always_comb begin
      logic [COORD_W-1:0] ni, nj, nk;
      ni = ci_ff;
      nj = cj_ff;
      nk = ck_ff;
      case (axis_ff)
         DIR_X:   ni = (32'(ci_ff) + 1 < 32'(sx)) ? COORD_W'(ci_ff + 1'b1) : '0;
         DIR_Y:   nj = (32'(cj_ff) + 1 < 32'(sy)) ? COORD_W'(cj_ff + 1'b1) : '0;
         DIR_Z:   nk = (32'(ck_ff) + 1 < 32'(sz)) ? COORD_W'(ck_ff + 1'b1) : '0;
         default: ni = ci_ff;
      endcase
      nb_site = SITE_W'(32'(ni) + 32'(sx) * (32'(nj) + 32'(sy) * 32'(nk)));
   end

   // read adder: sign-extended accumulation
   assign acc_sum = acc_ff + {{(SUM_W - 31){mem_rdata[31]}}, mem_rdata};

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      site_ff   <= site_in;
      ci_ff     <= ci_in;
      cj_ff     <= cj_in;
      ck_ff     <= ck_in;
      dir_ff    <= dir_in;
      sel_ff    <= sel_in;
      fluid_ff  <= fluid_in;
      dens_ff   <= dens_in;
      acc_ff    <= acc_in;
      pick_ff   <= pick_in;
      nb_ff     <= nb_in;
      axis_ff   <= axis_in;
      nsite_ff  <= nsite_in;
      kind_ff   <= kind_in;
      status_ff <= status_in;
      osite_ff  <= osite_in;
   end

   // next state and memory control
   always_comb begin
      state_in  = state_ff;
      site_in   = site_ff;
      ci_in     = ci_ff;
      cj_in     = cj_ff;
      ck_in     = ck_ff;
      dir_in    = dir_ff;
      sel_in    = sel_ff;
      fluid_in  = fluid_ff;
      dens_in   = dens_ff;
      acc_in    = acc_ff;
      pick_in   = pick_ff;
      nb_in     = nb_ff;
      axis_in   = axis_ff;
      nsite_in  = nsite_ff;
      kind_in   = kind_ff;
      status_in = status_ff;
      osite_in  = osite_ff;
      mem_req   = '{we: 1'b0, addr: {site_ff, dir_ff}, wdata: dens_ff[0] ? 32'd0 : 32'd0};
      flag_we   = 1'b0;
      flag_addr = site_ff;
      flag_wdata = fluid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               site_in  = site_t;
               fluid_in = fluid;
               dir_in   = 3'd0;
               osite_in = site;
               sel_in   = direction;
               acc_in   = '0;
               pick_in  = '0;
               if (op == OP_LOAD) begin
                  if (32'(site) < 32'(sx) * 32'(sy) * 32'(sz)) begin
                     state_in = ST_LOAD;
                     dens_in  = third[30:0];
                     pick_in  = fluid ? ninth : NEG_ONE;
                     if (!fluid) dens_in = NEG_ONE[30:0];
                  end
               end else if (op == OP_STEP) begin
                  kind_in   = 1'b0;
                  status_in = 1'b0;
                  site_in   = '0;
                  ci_in     = '0;
                  cj_in     = '0;
                  ck_in     = '0;
                  state_in  = ST_SW_FLAG;
               end else if (op == OP_READ) begin
                  kind_in = 1'b1;
                  if (32'(site) < 32'(sx) * 32'(sy) * 32'(sz)) begin
                     status_in = 1'b0;
                     state_in  = ST_RD_ISSUE;
                  end else begin
                     status_in = 1'b1;
                     state_in  = ST_OUT;
                  end
               end
            end
         end
         // write seven words, the flag together with the last one
         ST_LOAD: begin
            mem_req.we    = 1'b1;
            mem_req.wdata = (dir_ff == 3'd0)
                            ? (fluid_ff ? {1'b0, dens_ff} : NEG_ONE) : pick_ff;
            if (dir_ff == 3'(NUM_DIRS - 1)) begin
               flag_we  = 1'b1;
               state_in = ST_IDLE;
            end
            dir_in = dir_ff + 3'd1;
         end
         // stream seven words through the adder
         ST_RD_ISSUE: begin
            dir_in   = dir_ff + 3'd1;
            state_in = ST_RD_ACC;
         end
         ST_RD_ACC: begin
            acc_in = acc_sum;
            if (dir_ff - 3'd1 == sel_ff) pick_in = mem_rdata;
            if (dir_ff == 3'(NUM_DIRS)) begin
               state_in = ST_RD_DONE;
            end else begin
               dir_in = dir_ff + 3'd1;
            end
         end
         ST_RD_DONE: begin
            fluid_in = flag_rdata;
            if (!flag_rdata || acc_ff[SUM_W]) acc_in = '0;
            state_in = ST_OUT;
         end
         // streaming walk: fetch flag of current site
         ST_SW_FLAG: begin
            axis_in  = DIR_X;
            state_in = ST_SW_WAIT;
         end
         ST_SW_WAIT: begin
            if (flag_rdata) begin
               state_in = ST_SW_NB;
            end else begin
               state_in = ST_SW_NEXT;
            end
         end
         // read neighbor even value
         ST_SW_NB: begin
            nsite_in     = nb_site;
            mem_req.addr = {nb_site, 3'({axis_ff, 1'b0} + 3'd2)};
            state_in     = ST_SW_OWN;
         end
         // read own odd value, capture neighbor
         ST_SW_OWN: begin
            nb_in        = mem_rdata;
            mem_req.addr = {site_ff, 3'({axis_ff, 1'b0} + 3'd1)};
            state_in     = ST_SW_WRITE;
         end
         ST_SW_WRITE: begin
            pick_in = mem_rdata;
            if (nb_ff[31]) begin
               state_in = ST_SW_WRITE2;
            end else begin
               mem_req.we    = 1'b1;
               mem_req.addr  = {nsite_ff, 3'({axis_ff, 1'b0} + 3'd2)};
               mem_req.wdata = mem_rdata;
               state_in      = ST_SW_WRITE2;
            end
         end
         ST_SW_WRITE2: begin
            if (!nb_ff[31]) begin
               mem_req.we    = 1'b1;
               mem_req.addr  = {site_ff, 3'({axis_ff, 1'b0} + 3'd1)};
               mem_req.wdata = nb_ff;
            end
            if (axis_ff == DIR_Z) begin
               state_in = ST_SW_NEXT;
            end else begin
               axis_in  = (axis_ff == DIR_X) ? DIR_Y : DIR_Z;
               state_in = ST_SW_NB;
            end
         end
         // advance site and coordinates
         ST_SW_NEXT: begin
            if (last_site) begin
               state_in = ST_OUT;
            end else begin
               site_in  = site_ff + 1'b1;
               state_in = ST_SW_FLAG;
               if (32'(ci_ff) + 1 < 32'(sx)) begin
                  ci_in = ci_ff + 1'b1;
               end else begin
                  ci_in = '0;
                  if (32'(cj_ff) + 1 < 32'(sy)) begin
                     cj_in = cj_ff + 1'b1;
                  end else begin
                     cj_in = '0;
                     ck_in = ck_ff + 1'b1;
                  end
               end
            end
         end
         // hold result until taken
         ST_OUT: begin
            if (!out_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign out_kind    = kind_ff;
   assign out_status  = status_ff;
   assign out_site    = kind_ff ? osite_ff : 12'd0;
   assign out_fluid   = kind_ff && !status_ff && fluid_ff;
   assign out_density = (kind_ff && !status_ff) ? acc_ff[SUM_W-1:0] : '0;
   assign out_value   = (kind_ff && !status_ff && sel_ff < 3'(NUM_DIRS)) ? pick_ff : '0;

endmodule

// ===== bench/tb_lattice_d3q7_stream_swap_unit.sv =====
// ----------------------------------------------------------------------------
// tb_lattice_d3q7_stream_swap_unit: self-checking bench for the D3Q7 store
// Loads small lattices, mixes loads, streaming steps and reads, predicts each
// answer with a local lattice copy and compares every field of each response.
// ----------------------------------------------------------------------------
module tb_lattice_d3q7_stream_swap_unit;
   import d3q7_pkg::*;

   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int LAT_SITES = MAX_EDGE * MAX_EDGE * MAX_EDGE;

   typedef struct {
      logic        kind;
      logic [11:0] site_out;
      logic        fluid_out;
      logic [33:0] site_density;
      logic [31:0] value;
      logic        status;
   } lattice_answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = OP_NONE;
   logic [11:0] req_site = '0;
   logic        req_fluid = 1'b0;
   logic [30:0] req_density = '0;
   logic [2:0]  req_direction = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [11:0] rsp_site_out;
   logic        rsp_fluid_out;
   logic [33:0] rsp_site_density;
   logic signed [31:0] rsp_value;
   logic        rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = REG_SIZE_X;
   logic [4:0]  csr_data = '0;

   // local copy of the lattice
   logic [4:0]  size_reg [3];
   logic        site_fluid [LAT_SITES];
   logic [31:0] site_dist [NUM_DIRS][LAT_SITES];

   lattice_answer_type pending_answers[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off_left = 0;

   lattice_d3q7_stream_swap_unit uut (.*);

   always #1 clock = ~clock;

   // abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver: long hold-off first, otherwise random stall
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left = hold_off_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // compare each accepted response with the oldest expected answer
   always @(posedge clock) begin
      lattice_answer_type exp_ans;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            $error("unexpected response kind=%0d site=%0d", rsp_kind, rsp_site_out);
            mismatch_count++;
         end else begin
            exp_ans = pending_answers.pop_front();
            if (rsp_kind !== exp_ans.kind) begin
               $error("kind: expected %0d got %0d", exp_ans.kind, rsp_kind);
               mismatch_count++;
            end
            if (rsp_site_out !== exp_ans.site_out) begin
               $error("site_out: expected %0d got %0d", exp_ans.site_out, rsp_site_out);
               mismatch_count++;
            end
            if (rsp_fluid_out !== exp_ans.fluid_out) begin
               $error("fluid_out: expected %0d got %0d", exp_ans.fluid_out, rsp_fluid_out);
               mismatch_count++;
            end
            if (rsp_site_density !== exp_ans.site_density) begin
               $error("site_density: expected %h got %h", exp_ans.site_density,
                      rsp_site_density);
               mismatch_count++;
            end
            if (rsp_value !== exp_ans.value) begin
               $error("value: expected %h got %h", exp_ans.value, rsp_value);
               mismatch_count++;
            end
            if (rsp_status !== exp_ans.status) begin
               $error("status: expected %0d got %0d", exp_ans.status, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   function automatic int edge_len(input logic [4:0] r);
      if (r == 5'd0) return 1;
      if (int'(r) > MAX_EDGE) return MAX_EDGE;
      return int'(r);
   endfunction

   function automatic int lattice_sites();
      return edge_len(size_reg[0]) * edge_len(size_reg[1]) * edge_len(size_reg[2]);
   endfunction

   // exchange odd value of a site with the opposite value of its neighbor unless that value is negative
   function automatic void swap_link(input int n, input int nb, input int odd_dir);
      logic [31:0] held;
      held = site_dist[odd_dir + 1][nb];
      if (!held[31]) begin
         site_dist[odd_dir + 1][nb] = site_dist[odd_dir][n];
         site_dist[odd_dir][n] = held;
      end
   endfunction

   function automatic void stream_lattice();
      int sx, sy, sz, plane, total, i, j, k;
      sx = edge_len(size_reg[0]);
      sy = edge_len(size_reg[1]);
      sz = edge_len(size_reg[2]);
      plane = sx * sy;
      total = plane * sz;
      for (int n = 0; n < total; n++) begin
         k = n / plane;
         j = (n - plane * k) / sx;
         i = n - plane * k - sx * j;
         if (site_fluid[n]) begin
            swap_link(n, (i + 1 < sx) ? n + 1 : n + 1 - sx, 1);
            swap_link(n, (j + 1 < sy) ? n + sx : n + sx - plane, 3);
            swap_link(n, (k + 1 < sz) ? n + plane : n + plane - total, 5);
         end
      end
   endfunction

   // update the lattice copy for one accepted request, queue its answer
   function automatic void predict_request(input op_type op, input logic [11:0] site,
                                           input logic fl, input logic [30:0] dens,
                                           input logic [2:0] dir);
      lattice_answer_type ans;
      longint sum;
      int total;
      total = lattice_sites();
      ans = '{kind: 1'b0, site_out: '0, fluid_out: 1'b0, site_density: '0,
              value: '0, status: 1'b0};
      case (op)
         OP_LOAD: begin
            if (int'(site) < total) begin
               site_fluid[site] = fl;
               for (int d = 0; d < NUM_DIRS; d++) begin
                  if (fl) site_dist[d][site] = (d == 0) ? 32'(dens / 3) : 32'(dens / 9);
                  else site_dist[d][site] = NEG_ONE;
               end
            end
         end
         OP_STEP: begin
            stream_lattice();
            pending_answers.push_back(ans);
         end
         OP_READ: begin
            ans.kind = 1'b1;
            ans.site_out = site;
            if (int'(site) >= total) begin
               ans.status = 1'b1;
            end else begin
               ans.fluid_out = site_fluid[site];
               if (site_fluid[site]) begin
                  sum = 0;
                  for (int d = 0; d < NUM_DIRS; d++)
                     sum += longint'($signed(site_dist[d][site]));
                  if (sum < 0) sum = 0;
                  ans.site_density = 34'(sum);
               end
               if (dir < NUM_DIRS) ans.value = site_dist[dir][site];
            end
            pending_answers.push_back(ans);
         end
         default: ;
      endcase
   endfunction

   // offer one request, hold it until accepted
   task automatic send_request(input op_type op, input logic [11:0] site,
                               input logic fl, input logic [30:0] dens,
                               input logic [2:0] dir);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_site <= site;
      req_fluid <= fl;
      req_density <= dens;
      req_direction <= dir;
      do @(posedge clock); while (req_stall);
      predict_request(op, site, fl, dens, dir);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [4:0] data);
      @(negedge clock);
      req_valid <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx <= REG_SIZE_Z) size_reg[idx] = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait for every answer, then let a trailing load finish
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_answers.size() > 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic set_lattice(input logic [4:0] sx, input logic [4:0] sy,
                              input logic [4:0] sz);
      drain();
      write_reg(REG_SIZE_X, sx);
      write_reg(REG_SIZE_Y, sy);
      write_reg(REG_SIZE_Z, sz);
   endtask

   task automatic load_every_site();
      for (int s = 0; s < lattice_sites(); s++)
         send_request(OP_LOAD, 12'(s), ($urandom_range(3) != 0), 31'($urandom), 3'd0);
   endtask

   task automatic random_request();
      int pick, total;
      logic [11:0] any_site;
      total = lattice_sites();
      pick = $urandom_range(99);
      any_site = 12'($urandom);
      if (pick < 45)
         send_request(OP_READ, 12'($urandom_range(total - 1)), 1'b0, 31'($urandom),
                      3'($urandom_range(7)));
      else if (pick < 65)
         send_request(OP_LOAD, 12'($urandom_range(total - 1)), ($urandom_range(3) != 0),
                      31'($urandom), 3'($urandom));
      else if (pick < 80)
         send_request(OP_STEP, any_site, 1'($urandom), 31'($urandom), 3'($urandom));
      else if (pick < 90)
         send_request(OP_READ, any_site, 1'($urandom), 31'($urandom),
                      3'($urandom_range(7)));
      else if (pick < 95)
         send_request(OP_LOAD, any_site, 1'($urandom), 31'($urandom), 3'($urandom));
      else
         send_request(OP_NONE, any_site, 1'($urandom), 31'($urandom), 3'($urandom));
   endtask

   task automatic run_phase(input logic [4:0] sx, input logic [4:0] sy,
                            input logic [4:0] sz, input int idle_pct,
                            input int stall_pct, input int count);
      set_lattice(sx, sy, sz);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      load_every_site();
      repeat (count) random_request();
   endtask

   // edge values, every operation and the special cases on a 2x2x2 lattice
   task automatic test_directed();
      set_lattice(5'd2, 5'd2, 5'd2);
      write_reg(REG_UNUSED, 5'd1);
      for (int s = 0; s < 8; s++)
         send_request(OP_LOAD, 12'(s), (s % 3 != 2),
                      (s == 0) ? 31'h7FFF_FFFF : (s == 1) ? 31'd0 : 31'($urandom), 3'd0);
      send_request(OP_LOAD, 12'd8, 1'b1, 31'd12345, 3'd0);
      send_request(OP_LOAD, 12'hFFF, 1'b1, 31'd99, 3'd7);
      send_request(OP_READ, 12'd0, 1'b0, 31'd0, 3'd0);
      send_request(OP_READ, 12'd2, 1'b0, 31'd0, 3'd6);
      send_request(OP_READ, 12'hFFF, 1'b0, 31'd0, 3'd1);
      send_request(OP_READ, 12'd3, 1'b0, 31'd0, 3'd7);
      send_request(OP_NONE, 12'd1, 1'b1, 31'h7FFF_FFFF, 3'd7);
      send_request(OP_STEP, 12'd0, 1'b0, 31'd0, 3'd0);
      for (int d = 0; d < NUM_DIRS; d++)
         send_request(OP_READ, 12'(d), 1'b0, 31'd0, 3'(d));
      send_request(OP_STEP, 12'd0, 1'b0, 31'd0, 3'd0);
   endtask

   // a small lattice, then each extent at its largest in turn, under different idle and stall mixes
   task automatic test_extreme_sizes();
      run_phase(5'd3, 5'd2, 5'd2, 0, 0, 70);
      run_phase(5'd16, 5'd1, 5'd1, 64, 0, 70);
      run_phase(5'd1, 5'd16, 5'd1, 0, 64, 70);
      run_phase(5'd1, 5'd1, 5'd16, 30, 30, 70);
   endtask

   // zero and oversize registers clamp to 1 and the maximum edge
   task automatic test_clamped_sizes();
      run_phase(5'd0, 5'd5, 5'd31, 30, 30, 60);
   endtask

   // long receiver hold-off blocks new requests, then a drain and a random idle and stall mix
   task automatic test_back_pressure();
      set_lattice(5'd4, 5'd3, 5'd2);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      load_every_site();
      hold_off_left = 300;
      repeat (40) random_request();
      drain();
      send_idle_pct = 30;
      recv_stall_pct = 30;
      repeat (60) random_request();
   endtask

   initial begin
      size_reg[0] = 5'd16;
      size_reg[1] = 5'd16;
      size_reg[2] = 5'd16;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_extreme_sizes();
      test_clamped_sizes();
      test_back_pressure();
      drain();
      if (mismatch_count == 0 && pending_answers.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
